@@ sv/tslpm_pkg.sv @@
package tslpm_pkg;

  localparam int unsigned PTR_W = 21;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned REC_W = 17;
  localparam int unsigned PEND_W = 18;
  localparam int unsigned DROP_W = 32;

  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam int unsigned STATUS_W = 3;

  localparam logic [PTR_W-1:0] MAX_SEGMENT_BYTES = 21'd1048576;
  localparam logic [REC_W-1:0] HEADER_BYTES = 17'd12;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_BYTES = 16'd4096;
  localparam logic [PTR_W-1:0] CAP_RESET = 21'd1048576;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_POP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_LEN = 3'd1,
    ST_TOO_BIG = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BAD_HDR = 3'd4
  } status_t;

endpackage

@@ sv/two_segment_log_pointer_manager_core.sv @@
// Flow: an input transfer loads the input register; the item then moves on to the result
// register once that register is empty or out_tready is high, and out_tvalid rises.
// Throughput: one item per cycle while out_tready does not stall; the input register feeds
// single-pass pointer logic whose state updates land in the same cycle the result is registered.
// Reset (rst_n low, synchronous): both segments cleared, segment 0 active, drop count
// zero, segment capacity 1048576, both stages empty.
module two_segment_log_pointer_manager_core
  import tslpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_wr_en,
  input  logic [PTR_W-1:0]       cfg_wr_data,   // segment_capacity

  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // [15:0] payload_length, [16] discarded
  input  logic                   in_tuser,      // op

  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,     // [0] segment, [21:1] byte_offset,
                                                // [22] rotated, [39:23] dropped_now,
                                                // [57:40] pending_records,
                                                // [89:58] dropped_total
  output logic [STATUS_W-1:0]    out_tuser      // status
);

  logic [PTR_W-1:0]  cap_r;

  logic              in_vld_r;
  op_t               in_op_r;
  logic [LEN_W-1:0]  in_len_r;
  logic              in_disc_r;

  logic [PTR_W-1:0]  head_r [2];
  logic [PTR_W-1:0]  tail_r [2];
  logic [CNT_W-1:0]  cnt_r  [2];
  logic              act_r;
  logic [DROP_W-1:0] drop_cnt_r;

  logic [PTR_W-1:0]  head_nxt [2];
  logic [PTR_W-1:0]  tail_nxt [2];
  logic [CNT_W-1:0]  cnt_nxt  [2];
  logic              act_nxt;
  logic [DROP_W-1:0] drop_cnt_nxt;

  logic              out_vld_r;
  status_t           out_st_r;
  logic              out_seg_r;
  logic [PTR_W-1:0]  out_off_r;
  logic              out_rot_r;
  logic [CNT_W-1:0]  out_drop_r;
  logic [PEND_W-1:0] out_pend_r;

  status_t           st;
  logic              seg;
  logic [PTR_W-1:0]  off;
  logic              rot;
  logic [CNT_W-1:0]  dropped;
  logic [PEND_W-1:0] pend;
  logic              fire;

  logic [REC_W-1:0]  rec;
  logic              len_bad;
  logic              tgt;
  logic [PTR_W-1:0]  tail_base;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W-1:0]  cnt_dec;
  logic [DROP_W:0]   drop_sum;

  assign fire = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  always_comb begin
    rec       = HEADER_BYTES + {1'b0, in_len_r};
    len_bad   = (in_len_r == '0) || (in_len_r > MAX_PAYLOAD_BYTES);
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    st        = ST_OK;
    seg       = act_r;
    off       = '0;
    rot       = 1'b0;
    dropped   = '0;
    tgt       = act_r;
    tail_base = '0;
    cnt_base  = '0;
    cnt_dec   = '0;
    if (in_op_r == OP_ENQ) begin
      if (len_bad) begin
        st = ST_BAD_LEN;
      end else if ({4'b0, rec} > cap_r) begin
        st = ST_TOO_BIG;
      end else begin
        if (({1'b0, tail_r[act_r]} + {5'b0, rec}) > {1'b0, cap_r}) begin
          rot          = 1'b1;
          tgt          = ~act_r;
          dropped      = cnt_r[~act_r];
          act_nxt      = ~act_r;
          head_nxt[~act_r] = '0;
          tail_base    = '0;
          cnt_base     = '0;
        end else begin
          tail_base    = tail_r[act_r];
          cnt_base     = cnt_r[act_r];
        end
        seg           = tgt;
        off           = tail_base;
        tail_nxt[tgt] = tail_base + {4'b0, rec};
        cnt_nxt[tgt]  = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
      end
    end else begin
      if ((cnt_r[0] == '0) && (cnt_r[1] == '0)) begin
        st  = ST_EMPTY;
        seg = 1'b0;
      end else begin
        tgt     = (cnt_r[~act_r] != '0) ? ~act_r : act_r;
        seg     = tgt;
        off     = head_r[tgt];
        cnt_dec = cnt_r[tgt] - 1'b1;
        if (len_bad) begin
          st = ST_BAD_HDR;
        end else begin
          if (cnt_dec == '0) begin
            head_nxt[tgt] = '0;
            tail_nxt[tgt] = '0;
            cnt_nxt[tgt]  = '0;
          end else begin
            head_nxt[tgt] = head_r[tgt] + {4'b0, rec};
            cnt_nxt[tgt]  = cnt_dec;
          end
          if (in_disc_r) begin
            dropped = {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
      end
    end
    drop_sum     = {1'b0, drop_cnt_r} + {{(DROP_W+1-CNT_W){1'b0}}, dropped};
    drop_cnt_nxt = drop_sum[DROP_W] ? {DROP_W{1'b1}} : drop_sum[DROP_W-1:0];
    pend         = {1'b0, cnt_nxt[0]} + {1'b0, cnt_nxt[1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      head_r     <= '{default: '0};
      tail_r     <= '{default: '0};
      cnt_r      <= '{default: '0};
      act_r      <= 1'b0;
      drop_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= (cfg_wr_data > MAX_SEGMENT_BYTES) ? MAX_SEGMENT_BYTES : cfg_wr_data;
      end
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (fire) begin
        out_vld_r  <= 1'b1;
        head_r     <= head_nxt;
        tail_r     <= tail_nxt;
        cnt_r      <= cnt_nxt;
        act_r      <= act_nxt;
        drop_cnt_r <= drop_cnt_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= op_t'(in_tuser);
      in_len_r  <= in_tdata[LEN_W-1:0];
      in_disc_r <= in_tdata[LEN_W];
    end
    if (fire) begin
      out_st_r   <= st;
      out_seg_r  <= seg;
      out_off_r  <= off;
      out_rot_r  <= rot;
      out_drop_r <= dropped;
      out_pend_r <= pend;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {6'b0, drop_cnt_r, out_pend_r, out_drop_r, out_rot_r,
                       out_off_r, out_seg_r};

  a_err_no_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_st_r != ST_OK) |-> !out_rot_r && (out_drop_r == '0))
    else $error("error result reports rotation or drops");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |-> !in_tready && !fire)
    else $error("input stage advanced into a full result register");

  a_drop_mono: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> drop_cnt_r >= $past(drop_cnt_r))
    else $error("drop count decreased");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !in_vld_r)
    else $error("stage valid after reset");

endmodule

@@ bench/two_segment_log_pointer_manager_core_tb.sv @@
module two_segment_log_pointer_manager_core_tb;
  import tslpm_pkg::*;

  typedef struct packed {
    status_t           st;
    logic              seg;
    logic [PTR_W-1:0]  off;
    logic              rot;
    logic [CNT_W-1:0]  dn;
    logic [PEND_W-1:0] pend;
    logic [DROP_W-1:0] tot;
  } log_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    op_t              op;
    logic [LEN_W-1:0] len;
    logic             disc;
    bit               chk;
    log_res_t         want;
    logic [PTR_W-1:0] cap;
  } log_item_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [PTR_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] payload_length, [16] discarded
  logic                   in_tuser;   // op
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] segment, [21:1] byte_offset, [22] rotated,
                                      // [39:23] dropped_now, [57:40] pending_records,
                                      // [89:58] dropped_total
  logic [STATUS_W-1:0]    out_tuser;  // status

  two_segment_log_pointer_manager_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // predictor state
  logic [PTR_W-1:0]  seg_head [2];
  logic [PTR_W-1:0]  seg_tail [2];
  logic [CNT_W-1:0]  seg_cnt [2];
  logic              act_seg;
  logic [DROP_W-1:0] drop_total;
  logic [PTR_W-1:0]  seg_cap;

  log_res_t    due_results [$];
  log_item_t   dir_rows [$];
  int unsigned n_sent;
  int unsigned n_bad;
  int unsigned burst_left;
  bit          idle_on;

  function automatic void clear_seg(logic s);
    seg_head[s] = '0;
    seg_tail[s] = '0;
    seg_cnt[s]  = '0;
  endfunction

  function automatic int unsigned pending_now();
    return int'(seg_cnt[0]) + int'(seg_cnt[1]);
  endfunction

  function automatic int unsigned usable_cap();
    return (seg_cap > MAX_SEGMENT_BYTES) ? int'(MAX_SEGMENT_BYTES) : int'(seg_cap);
  endfunction

  function automatic logic [DROP_W-1:0] sat_drop(logic [DROP_W-1:0] a, int unsigned b);
    logic [DROP_W:0] sum;
    sum = {1'b0, a} + (DROP_W+1)'(b);
    return sum[DROP_W] ? '1 : sum[DROP_W-1:0];
  endfunction

  function automatic log_res_t apply_log_op(op_t op, logic [LEN_W-1:0] len, logic disc);
    log_res_t    r;
    int unsigned lim;
    int unsigned rec;
    logic        nx;
    logic        src;
    r     = '0;
    r.st  = ST_OK;
    r.seg = act_seg;
    lim   = usable_cap();
    rec   = int'(HEADER_BYTES) + int'(len);
    if (op == OP_ENQ) begin
      if (len == '0 || len > MAX_PAYLOAD_BYTES) begin
        r.st = ST_BAD_LEN;
      end else if (rec > lim) begin
        r.st = ST_TOO_BIG;
      end else begin
        if (int'(seg_tail[act_seg]) + rec > lim) begin
          nx         = ~act_seg;
          r.rot      = 1'b1;
          r.dn       = seg_cnt[nx];
          drop_total = sat_drop(drop_total, int'(seg_cnt[nx]));
          clear_seg(nx);
          act_seg    = nx;
        end
        r.seg = act_seg;
        r.off = seg_tail[act_seg];
        seg_tail[act_seg] = seg_tail[act_seg] + rec[PTR_W-1:0];
        if (seg_cnt[act_seg] != CNT_MAX) seg_cnt[act_seg] = seg_cnt[act_seg] + 1'b1;
      end
    end else if (pending_now() == 0) begin
      r.st  = ST_EMPTY;
      r.seg = 1'b0;
    end else begin
      nx    = ~act_seg;
      src   = (seg_cnt[nx] != '0) ? nx : act_seg;
      r.seg = src;
      r.off = seg_head[src];
      if (len == '0 || len > MAX_PAYLOAD_BYTES) begin
        r.st = ST_BAD_HDR;
      end else begin
        seg_head[src] = seg_head[src] + rec[PTR_W-1:0];
        seg_cnt[src]  = seg_cnt[src] - 1'b1;
        if (disc) begin
          r.dn       = 1;
          drop_total = sat_drop(drop_total, 1);
        end
        if (seg_cnt[src] == '0) clear_seg(src);
      end
    end
    r.pend = PEND_W'(pending_now());
    r.tot  = drop_total;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len(op_t op);
    int unsigned k;
    int unsigned top;
    k   = $urandom_range(0, 19);
    top = usable_cap() / 4;
    if (op == OP_POP || top > MAX_PAYLOAD_BYTES) top = MAX_PAYLOAD_BYTES;
    if (top == 0) top = 1;
    case (k)
      0:       return '0;
      1:       return LEN_W'($urandom_range(4097, 65535));
      2:       return MAX_PAYLOAD_BYTES;
      default: return LEN_W'($urandom_range(1, top));
    endcase
  endfunction

  function automatic string fmt_res(log_res_t r);
    return $sformatf("st=%0d seg=%0d off=%0d rot=%0d dn=%0d pend=%0d tot=%0d",
                     r.st, r.seg, r.off, r.rot, r.dn, r.pend, r.tot);
  endfunction

  function automatic void row(op_t op, logic [LEN_W-1:0] len, logic disc);
    log_item_t t;
    t.kind = ROW_ITEM;
    t.op   = op;
    t.len  = len;
    t.disc = disc;
    t.chk  = 1'b0;
    t.want = '0;
    t.cap  = '0;
    dir_rows.push_back(t);
  endfunction

  // typed expectation, rotated and dropped_now zero
  function automatic void row_chk(op_t op, logic [LEN_W-1:0] len, logic disc, status_t st,
                                  logic seg, logic [PTR_W-1:0] off, logic [PEND_W-1:0] pend,
                                  logic [DROP_W-1:0] tot);
    log_item_t t;
    t.kind      = ROW_ITEM;
    t.op        = op;
    t.len       = len;
    t.disc      = disc;
    t.chk       = 1'b1;
    t.want      = '0;
    t.want.st   = st;
    t.want.seg  = seg;
    t.want.off  = off;
    t.want.pend = pend;
    t.want.tot  = tot;
    t.cap       = '0;
    dir_rows.push_back(t);
  endfunction

  function automatic void row_cap(logic [PTR_W-1:0] cap);
    log_item_t t;
    t.kind = ROW_CFG;
    t.op   = OP_ENQ;
    t.len  = '0;
    t.disc = 1'b0;
    t.chk  = 1'b0;
    t.want = '0;
    t.cap  = cap;
    dir_rows.push_back(t);
  endfunction

  task automatic send_item(op_t op, logic [LEN_W-1:0] len, logic disc, bit chk,
                           log_res_t want);
    log_res_t p;
    if (idle_on && burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'd0, disc, len};
    in_tuser  = op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = apply_log_op(op, len, disc);
    due_results.push_back(chk ? want : p);
    n_sent++;
    if (burst_left != 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic send_rand(op_t op, logic [LEN_W-1:0] len);
    send_item(op, len, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic set_capacity(logic [PTR_W-1:0] val);
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    seg_cap   = val;
  endtask

  task automatic run_mix(logic [PTR_W-1:0] cap, int unsigned n);
    op_t op;
    set_capacity(cap);
    idle_on = ($urandom_range(0, 3) != 0);
    repeat (n) begin
      op = ($urandom_range(0, 99) < 55) ? OP_ENQ : OP_POP;
      send_rand(op, pick_len(op));
    end
  endtask

  // result side
  always @(posedge clk) begin : mon
    log_res_t got;
    log_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[0], out_tdata[21:1], out_tdata[22], out_tdata[39:23],
             out_tdata[57:40], out_tdata[89:58]};
      if (due_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected transfer: %s", fmt_res(got));
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) $display("mismatch: exp %s / got %s", fmt_res(want), fmt_res(got));
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off to back the block up
  initial begin
    int unsigned tick;
    int unsigned hold_left;
    bit          held;
    tick       = 0;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!held && n_sent >= 40) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        case ((tick / 97) % 4)
          0:       out_tready = 1'b1;
          1:       out_tready = 1'($urandom_range(0, 1));
          2:       out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    op_t op;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    n_sent      = 0;
    n_bad       = 0;
    burst_left  = 0;
    idle_on     = 1'b0;
    clear_seg(1'b0);
    clear_seg(1'b1);
    act_seg    = 1'b0;
    drop_total = '0;
    seg_cap    = CAP_RESET;

    row_chk(OP_POP, 16'd5,     1'b0, ST_EMPTY,   1'b0, '0, 18'd0, 32'd0);
    row_chk(OP_ENQ, 16'd0,     1'b0, ST_BAD_LEN, 1'b0, '0, 18'd0, 32'd0);
    row_chk(OP_ENQ, 16'd4097,  1'b0, ST_BAD_LEN, 1'b0, '0, 18'd0, 32'd0);
    row_chk(OP_ENQ, 16'hFFFF,  1'b1, ST_BAD_LEN, 1'b0, '0, 18'd0, 32'd0);
    row_chk(OP_ENQ, 16'd4096,  1'b0, ST_OK,      1'b0, '0, 18'd1, 32'd0);
    row(OP_ENQ, 16'd1, 1'b0);
    row(OP_ENQ, 16'd1, 1'b1);
    row_chk(OP_POP, 16'd0,     1'b1, ST_BAD_HDR, 1'b0, '0, 18'd3, 32'd0);
    row(OP_POP, 16'd4097, 1'b0);
    row(OP_POP, 16'd4096, 1'b0);
    row(OP_POP, 16'd1,    1'b1);
    row(OP_POP, 16'd1,    1'b1);
    row(OP_POP, 16'hFFFF, 1'b1);
    row_cap(21'd14);
    row_chk(OP_ENQ, 16'd3,     1'b0, ST_TOO_BIG, 1'b0, '0, 18'd0, 32'd2);
    row(OP_ENQ, 16'd2, 1'b0);
    row(OP_ENQ, 16'd1, 1'b0);
    row(OP_ENQ, 16'd1, 1'b1);
    row(OP_ENQ, 16'd1, 1'b0);
    row(OP_POP, 16'd1, 1'b1);
    row(OP_POP, 16'd0, 1'b0);
    row(OP_POP, 16'd3, 1'b0);
    row(OP_ENQ, 16'hFFFF, 1'b0);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_capacity(dir_rows[i].cap);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].len, dir_rows[i].disc, dir_rows[i].chk,
                  dir_rows[i].want);
      end
    end

    run_mix(21'd200, 20);
    run_mix(21'd1000, 15);
    run_mix(21'd14, 10);
    run_mix(21'd60, 15);
    run_mix(21'd5000, 15);

    // oversized capacity; fill one segment, then pop with long headers so the head wraps
    set_capacity(21'h1FFFFF);
    idle_on = ($urandom_range(0, 1) != 0);
    while (pending_now() != 0) send_rand(OP_POP, 16'd1);
    repeat (530) begin
      if ($urandom_range(0, 49) == 0) send_rand(OP_ENQ, pick_len(OP_ENQ));
      else send_rand(OP_ENQ, LEN_W'($urandom_range(1, 64)));
    end
    while (pending_now() != 0) begin
      if ($urandom_range(0, 49) == 0) send_rand(OP_POP, pick_len(OP_POP));
      else send_rand(OP_POP, MAX_PAYLOAD_BYTES);
    end
    op = OP_POP;
    send_rand(op, pick_len(op));

    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_bad == 0 && due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tslpm_pkg.sv
sv/two_segment_log_pointer_manager_core.sv
bench/two_segment_log_pointer_manager_core_tb.sv
